// File: src/elsm_pkg.sv
// Shared types and constants for the extent list sector mapper.
package elsm_pkg;

    localparam int MAX_EXTENTS = 32;
    localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int TOT_W       = $clog2(MAX_EXTENTS + 1);

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_MAP    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [63:0] sector;
        logic [31:0] length;
    } extent_t;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic             shift_en;
        logic             append_en;
        logic [TOT_W-1:0] total;
    } chain_ctrl_t;

endpackage

// File: src/elsm_cell.sv
// One cell of the extent row: holds a single extent, loads on append, shifts on walk.
module elsm_cell
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic              load_en,
    input  elsm_pkg::extent_t load_ext,
    input  elsm_pkg::extent_t nbr_ext,
    output elsm_pkg::extent_t ext
);

    elsm_pkg::extent_t ext_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            ext_reg <= nbr_ext;
        end
        else if (load_en)
        begin
            ext_reg <= load_ext;
        end
    end

    assign ext = ext_reg;

endmodule

// File: src/elsm_ctrl.sv
// Request sequencer: extent count, walk over the rotating row, segment hold and output register.
module elsm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_op,
    input  logic [63:0]           in_start,
    input  logic [31:0]           in_length,
    input  elsm_pkg::extent_t     head_ext,
    output elsm_pkg::chain_ctrl_t chain_ctrl,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           out_sector,
    output logic [31:0]           out_length,
    output logic                  out_seg_valid,
    output logic                  out_last,
    output logic                  out_short
);

    localparam int IDX_W = elsm_pkg::IDX_W;
    localparam int TOT_W = elsm_pkg::TOT_W;

    elsm_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [63:0]       offset_reg, offset_next;
    logic [31:0]       wanted_reg, wanted_next;
    logic              pend_reg, pend_next;
    logic [63:0]       pend_sector_reg, pend_sector_next;
    logic [31:0]       pend_length_reg, pend_length_next;

    logic              oval_reg, oval_next;
    logic [63:0]       osector_reg, osector_next;
    logic [31:0]       olength_reg, olength_next;
    logic              oseg_reg, oseg_next;
    logic              olast_reg, olast_next;
    logic              oshort_reg, oshort_next;

    logic              can_emit;
    logic              active;
    logic [64:0]       diff;
    logic              skip;
    logic [31:0]       trim;
    logic [31:0]       seg_len;
    logic              found;
    logic              advance;
    logic              shift_en;
    logic              append_en;

    assign can_emit = !oval_reg || out_ready;

    // head extent against the remaining offset
    assign active  = (TOT_W'(idx_reg) < total_reg) && (wanted_reg != 32'd0);
    assign diff    = {1'b0, offset_reg} - {33'b0, head_ext.length};
    assign skip    = !diff[64];
    assign trim    = head_ext.length - offset_reg[31:0];
    assign seg_len = (trim > wanted_reg) ? wanted_reg : trim;
    assign found   = (state_reg == elsm_pkg::ST_WALK) && active && !skip;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        total_next       = total_reg;
        offset_next      = offset_reg;
        wanted_next      = wanted_reg;
        pend_next        = pend_reg;
        pend_sector_next = pend_sector_reg;
        pend_length_next = pend_length_reg;
        oval_next        = oval_reg && !out_ready;
        osector_next     = osector_reg;
        olength_next     = olength_reg;
        oseg_next        = oseg_reg;
        olast_next       = olast_reg;
        oshort_next      = oshort_reg;
        in_ready         = 1'b0;
        advance          = 1'b0;
        shift_en         = 1'b0;
        append_en        = 1'b0;

        case (state_reg)
            elsm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_op)
                        elsm_pkg::OP_APPEND:
                        begin
                            if (total_reg < TOT_W'(elsm_pkg::MAX_EXTENTS))
                            begin
                                append_en  = 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                        end
                        elsm_pkg::OP_CLEAR:
                        begin
                            total_next = '0;
                        end
                        elsm_pkg::OP_MAP:
                        begin
                            offset_next = in_start;
                            wanted_next = in_length;
                            pend_next   = 1'b0;
                            idx_next    = '0;
                            state_next  = elsm_pkg::ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            elsm_pkg::ST_WALK:
            begin
                // a new segment pushes the held one out, so it must wait for room
                advance  = !(found && pend_reg && !can_emit);
                shift_en = advance;
                if (advance)
                begin
                    if (found && pend_reg)
                    begin
                        oval_next    = 1'b1;
                        osector_next = pend_sector_reg;
                        olength_next = pend_length_reg;
                        oseg_next    = 1'b1;
                        olast_next   = 1'b0;
                        oshort_next  = 1'b0;
                    end
                    if (active)
                    begin
                        if (skip)
                        begin
                            offset_next = diff[63:0];
                        end
                        else
                        begin
                            offset_next      = '0;
                            wanted_next      = wanted_reg - seg_len;
                            pend_next        = 1'b1;
                            pend_sector_next = head_ext.sector + offset_reg;
                            pend_length_next = seg_len;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(elsm_pkg::MAX_EXTENTS - 1))
                    begin
                        idx_next   = '0;
                        state_next = elsm_pkg::ST_FINAL;
                    end
                end
            end
            elsm_pkg::ST_FINAL:
            begin
                if (can_emit)
                begin
                    oval_next    = 1'b1;
                    osector_next = pend_reg ? pend_sector_reg : 64'd0;
                    olength_next = pend_reg ? pend_length_reg : 32'd0;
                    oseg_next    = pend_reg;
                    olast_next   = 1'b1;
                    oshort_next  = (wanted_reg != 32'd0);
                    state_next   = elsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = elsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elsm_pkg::ST_IDLE;
            idx_reg   <= '0;
            total_reg <= '0;
            pend_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg      <= offset_next;
        wanted_reg      <= wanted_next;
        pend_sector_reg <= pend_sector_next;
        pend_length_reg <= pend_length_next;
        osector_reg     <= osector_next;
        olength_reg     <= olength_next;
        oseg_reg        <= oseg_next;
        olast_reg       <= olast_next;
        oshort_reg      <= oshort_next;
    end

    assign chain_ctrl.shift_en  = shift_en;
    assign chain_ctrl.append_en = append_en;
    assign chain_ctrl.total     = total_reg;

    assign out_valid     = oval_reg;
    assign out_sector    = osector_reg;
    assign out_length    = olength_reg;
    assign out_seg_valid = oseg_reg;
    assign out_last      = olast_reg;
    assign out_short     = oshort_reg;

endmodule

// File: src/extent_list_sector_mapper.sv
// Top level of the extent list sector mapper: row of extent cells and request sequencer.
//
//  channel  | dir | contents
//  s_axis   | in  | tuser: operation; tdata: extent_sector, extent_length, request_start,
//           |     |   request_length
//  m_axis   | out | tdata: segment_sector, segment_length; tuser: segment_valid, short_map;
//           |     |   tlast: last_segment
//
// Append and clear are handled in the idle state. A map request keeps the input closed while
// the walk visits every cell once and the final result is issued, plus any output stall: the
// extent row rotates one cell per cycle past the head while the walk is not held, so the walk
// always covers the full row and leaves it in its original order.
// Reset clears the extent count and control; cell contents are left as they are.
// A stalled output only holds the walk when a second segment is ready to go out.
module extent_list_sector_mapper
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [191:0]  s_axis_tdata,   // [63:0] extent_sector, [95:64] extent_length,
                                          // [159:96] request_start, [191:160] request_length
    input  logic [1:0]    s_axis_tuser,   // [1:0] operation
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [95:0]   m_axis_tdata,   // [63:0] segment_sector, [95:64] segment_length
    output logic [1:0]    m_axis_tuser,   // [0] segment_valid, [1] short_map
    output logic          m_axis_tlast
);

    localparam int N     = elsm_pkg::MAX_EXTENTS;
    localparam int TOT_W = elsm_pkg::TOT_W;

    elsm_pkg::extent_t     cell_ext [N];
    elsm_pkg::extent_t     load_ext;
    elsm_pkg::chain_ctrl_t chain_ctrl;
    logic [63:0]           out_sector;
    logic [31:0]           out_length;
    logic                  out_seg_valid;
    logic                  out_short;

    assign load_ext.sector = s_axis_tdata[63:0];
    assign load_ext.length = s_axis_tdata[95:64];

    // cell 0 is the head; each cell takes its upper neighbour, the last wraps to the head
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        elsm_cell u_cell
        (
            .clk      (clk),
            .shift_en (chain_ctrl.shift_en),
            .load_en  (chain_ctrl.append_en && (chain_ctrl.total == TOT_W'(i))),
            .load_ext (load_ext),
            .nbr_ext  (cell_ext[(i + 1) % N]),
            .ext      (cell_ext[i])
        );
    end

    elsm_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser),
        .in_start      (s_axis_tdata[159:96]),
        .in_length     (s_axis_tdata[191:160]),
        .head_ext      (cell_ext[0]),
        .chain_ctrl    (chain_ctrl),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_sector    (out_sector),
        .out_length    (out_length),
        .out_seg_valid (out_seg_valid),
        .out_last      (m_axis_tlast),
        .out_short     (out_short)
    );

    assign m_axis_tdata = {out_length, out_sector};
    assign m_axis_tuser = {out_short, out_seg_valid};

endmodule
